/* src/msd_pkg.sv */
// Shared types, register indexes and reset values for the motor stall command derater.
package msd_pkg;

  typedef struct packed {
    logic signed [15:0] requested_command;
    logic signed [15:0] speed_rpm;
    logic        [15:0] delta_ms;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] limited_command;
    logic               stall_active;
  } out_beat_t;

  typedef struct packed {
    logic        enable;
    logic [14:0] cmd_threshold;
    logic [14:0] speed_threshold;
    logic [15:0] grace_ms;
    logic [15:0] ramp_ms;
    logic [14:0] full_cmd;
    logic [14:0] sustain_cmd;
  } cfg_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ENABLE          = 3'd0;
  localparam cfg_idx_t REG_CMD_THRESHOLD   = 3'd1;
  localparam cfg_idx_t REG_SPEED_THRESHOLD = 3'd2;
  localparam cfg_idx_t REG_GRACE_MS        = 3'd3;
  localparam cfg_idx_t REG_RAMP_MS         = 3'd4;
  localparam cfg_idx_t REG_FULL_CMD        = 3'd5;
  localparam cfg_idx_t REG_SUSTAIN_CMD     = 3'd6;

  localparam logic        ENABLE_RST          = 1'b1;
  localparam logic [14:0] CMD_THRESHOLD_RST   = 15'd650;
  localparam logic [14:0] SPEED_THRESHOLD_RST = 15'd30;
  localparam logic [15:0] GRACE_MS_RST        = 16'd1000;
  localparam logic [15:0] RAMP_MS_RST         = 16'd1000;
  localparam logic [14:0] FULL_CMD_RST        = 15'd1000;
  localparam logic [14:0] SUSTAIN_CMD_RST     = 15'd350;

  // request to and response from the serial multiply-divide unit
  typedef struct packed {
    logic        start;
    logic [14:0] mcand;
    logic [15:0] mplier;
    logic [15:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [14:0] quot;
  } md_rsp_t;

endpackage

/* src/msd_cfg.sv */
// Configuration register file for the motor stall command derater.
module msd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  msd_pkg::cfg_idx_t               cfg_index_i,
  input  logic [msd_pkg::CfgDataW-1:0]    cfg_data_i,
  output msd_pkg::cfg_t                   cfg_o
);
  import msd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable          <= ENABLE_RST;
      cfg_q.cmd_threshold   <= CMD_THRESHOLD_RST;
      cfg_q.speed_threshold <= SPEED_THRESHOLD_RST;
      cfg_q.grace_ms        <= GRACE_MS_RST;
      cfg_q.ramp_ms         <= RAMP_MS_RST;
      cfg_q.full_cmd        <= FULL_CMD_RST;
      cfg_q.sustain_cmd     <= SUSTAIN_CMD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:          cfg_q.enable          <= cfg_data_i[0];
        REG_CMD_THRESHOLD:   cfg_q.cmd_threshold   <= cfg_data_i[14:0];
        REG_SPEED_THRESHOLD: cfg_q.speed_threshold <= cfg_data_i[14:0];
        REG_GRACE_MS:        cfg_q.grace_ms        <= cfg_data_i[15:0];
        REG_RAMP_MS:         cfg_q.ramp_ms         <= cfg_data_i[15:0];
        REG_FULL_CMD:        cfg_q.full_cmd        <= cfg_data_i[14:0];
        REG_SUSTAIN_CMD:     cfg_q.sustain_cmd     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/msd_muldiv.sv */
// Bit-serial shift-add multiplier followed by restoring divider, quotient of a*b/d.
module msd_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msd_pkg::md_req_t req_i,
  output msd_pkg::md_rsp_t rsp_o
);
  import msd_pkg::*;

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [14:0] mcand_q, mcand_d;
  logic [15:0] divisor_q, divisor_d;
  logic [31:0] work_q, work_d;

  logic [16:0] mul_sum;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  logic [15:0] new_rem;

  // multiply: add into the high half, shift the multiplier out of the low half
  assign mul_sum = {1'b0, work_q[31:16]} + {2'b00, (work_q[0] ? mcand_q : 15'd0)};
  // divide: high product bits already below the divisor, so 15 quotient bits
  assign trial   = {work_q[30:15], work_q[14]};
  assign ge      = trial >= {1'b0, divisor_q};
  assign diff    = trial - {1'b0, divisor_q};
  assign new_rem = ge ? diff[15:0] : trial[15:0];

  always_comb begin
    busy_d    = busy_q;
    div_d     = div_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    mcand_d   = mcand_q;
    divisor_d = divisor_q;
    work_d    = work_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      div_d     = 1'b0;
      cnt_d     = '0;
      mcand_d   = req_i.mcand;
      divisor_d = req_i.divisor;
      work_d    = {16'd0, req_i.mplier};
    end else if (busy_q && !div_q) begin
      work_d = {mul_sum, work_q[15:1]};
      if (cnt_q == 4'd15) begin
        div_d = 1'b1;
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end else if (busy_q) begin
      work_d = {1'b0, new_rem, work_q[13:0], ge};
      if (cnt_q == 4'd14) begin
        busy_d = 1'b0;
        div_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q   <= mcand_d;
    divisor_q <= divisor_d;
    work_q    <= work_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = work_q[14:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("muldiv started while busy");

  a_start_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && !div_q)
    else $error("muldiv did not enter multiply phase");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q |-> busy_q)
    else $error("divide phase without busy");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> work_q[14:0] <= mcand_q)
    else $error("quotient exceeds multiplicand");

endmodule

/* src/motor_stall_command_derater_top.sv */
// Top level of the motor stall command derater.
//
// Input beats (requested_command, speed_rpm, delta_ms) arrive on a
// valid/stall channel; each yields exactly one output beat (limited_command,
// stall_active) on a valid/stall channel. One beat is processed at a time.
// When no derate ramp applies the ceiling is taken from the configuration;
// inside the ramp a bit-serial multiply and restoring divide form the
// ceiling. A new input beat is taken only once the previous one has been
// placed in the output register. The output register frees the input side:
// a new beat may be taken while the previous result still waits; a
// finished result is held until the output register is free.
// Configuration writes use cfg_valid_i/cfg_ready_o (always ready) with a
// register index and data; write only while idle.
// Reset clears the stall timer, loads the default register values and
// leaves no output beat pending. While the receiver stalls, the output
// beat holds unchanged.
module motor_stall_command_derater_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  msd_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output msd_pkg::out_beat_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  msd_pkg::cfg_idx_t               cfg_index_i,
  input  logic [msd_pkg::CfgDataW-1:0]    cfg_data_i
);
  import msd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  cfg_t      cfg;
  md_req_t   md_req;
  md_rsp_t   md_rsp;

  logic [1:0]  state_q, state_d;
  in_beat_t    item_q, item_d;
  logic        stall_q, stall_d;
  logic        span_neg_q, span_neg_d;
  logic [14:0] ceil_q, ceil_d;
  logic [15:0] timer_q, timer_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_data_q, out_data_d;

  logic [15:0] cmd_u, spd_u, cmag, smag;
  logic        stall_now, past_grace, ramp_done, out_free, clamp;
  logic [15:0] ramp;
  logic [16:0] span;
  logic [14:0] span_mag;
  logic [15:0] cval, limited;
  logic [16:0] tsum;

  assign cfg_ready_o = 1'b1;

  msd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  msd_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // magnitudes; the most negative value maps to 32768
  assign cmd_u = item_q.requested_command;
  assign spd_u = item_q.speed_rpm;
  assign cmag  = cmd_u[15] ? (~cmd_u + 16'd1) : cmd_u;
  assign smag  = spd_u[15] ? (~spd_u + 16'd1) : spd_u;

  assign stall_now  = cfg.enable && (cmag > {1'b0, cfg.cmd_threshold})
                      && (smag < {1'b0, cfg.speed_threshold});
  assign past_grace = timer_q > cfg.grace_ms;
  assign ramp       = timer_q - cfg.grace_ms;
  assign ramp_done  = ramp >= cfg.ramp_ms;
  assign span       = {2'b00, cfg.full_cmd} - {2'b00, cfg.sustain_cmd};
  assign span_mag   = span[16] ? (cfg.sustain_cmd - cfg.full_cmd)
                               : (cfg.full_cmd - cfg.sustain_cmd);

  assign out_free = !out_valid_q || !out_stall_i;
  assign cval     = {1'b0, ceil_q};
  assign clamp    = stall_q && (cmag > cval);
  assign limited  = clamp ? (cmd_u[15] ? (~cval + 16'd1) : cval) : cmd_u;
  assign tsum     = {1'b0, timer_q} + {1'b0, item_q.delta_ms};

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    stall_d     = stall_q;
    span_neg_d  = span_neg_q;
    ceil_d      = ceil_q;
    timer_d     = timer_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    md_req.start   = 1'b0;
    md_req.mcand   = span_mag;
    md_req.mplier  = ramp;
    md_req.divisor = cfg.ramp_ms;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        stall_d    = stall_now;
        span_neg_d = span[16];
        if (stall_now && past_grace && !ramp_done) begin
          md_req.start = 1'b1;
          state_d      = S_DIV;
        end else begin
          ceil_d  = (stall_now && past_grace) ? cfg.sustain_cmd : cfg.full_cmd;
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (md_rsp.done) begin
          ceil_d  = span_neg_q ? (cfg.full_cmd + md_rsp.quot)
                               : (cfg.full_cmd - md_rsp.quot);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.limited_command = limited;
          out_data_d.stall_active    = stall_q;
          if (!stall_q) begin
            timer_d = '0;
          end else if (tsum[16]) begin
            timer_d = '1;
          end else begin
            timer_d = tsum[15:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    stall_q    <= stall_d;
    span_neg_q <= span_neg_d;
    ceil_q     <= ceil_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("finished beat not placed in output register");

  a_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free && !stall_q) |=> timer_q == 16'd0)
    else $error("stall timer not cleared");

  a_ceil_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |->
      (ceil_q <= cfg.full_cmd || ceil_q <= cfg.sustain_cmd) &&
      (ceil_q >= cfg.full_cmd || ceil_q >= cfg.sustain_cmd))
    else $error("ceiling outside full/sustain range");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (md_rsp.busy || md_rsp.done))
    else $error("waiting on idle muldiv");

endmodule
